// File: src/scl_pkg.sv
// Shared types and constants for the serial command line matcher.
// No dependencies; used by scl_match, serial_command_line_matcher and scl_checker.
package scl_pkg;

   localparam int LINE_BYTES = 32;
   localparam int LEN_W      = $clog2(LINE_BYTES);

   localparam logic [7:0] CHAR_START = 8'h7E;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam int PREFIX_LEN   = 5;
   localparam int TOGGLE_LEN   = 6;
   localparam int CANCEL_LEN   = 6;
   localparam int RECOVERY_LEN = 8;
   localparam int RESET_LEN    = 5;
   localparam int FORGET_LEN   = 6;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_TOGGLE     = 3'd1,
      CMD_CANCEL     = 3'd2,
      CMD_RECOVERY   = 3'd3,
      CMD_BAD_ACTION = 3'd4,
      CMD_BAD_PREFIX = 3'd5,
      CMD_TOO_LONG   = 3'd6
   } cmd_type;

   typedef struct packed {
      logic    consumed;
      cmd_type command;
   } result_type;

   typedef enum logic [2:0] {
      WORD_TOGGLE   = 3'd0,
      WORD_CANCEL   = 3'd1,
      WORD_RECOVERY = 3'd2,
      WORD_RESET    = 3'd3,
      WORD_FORGET   = 3'd4,
      WORD_PREFIX   = 3'd5
   } word_type;

   // Character at position idx of a keyword; past the end gives zero.
   function automatic logic [7:0] word_char(word_type w, logic [2:0] idx);
      logic [63:0] s;
      begin
         case (w)
            WORD_TOGGLE:   s = {"TOGGLE", 16'h0};
            WORD_CANCEL:   s = {"CANCEL", 16'h0};
            WORD_RECOVERY: s = "RECOVERY";
            WORD_RESET:    s = {"RESET", 24'h0};
            WORD_FORGET:   s = {"FORGET", 16'h0};
            WORD_PREFIX:   s = {"VREC:", 24'h0};
            default:       s = 64'h0;
         endcase
         word_char = s[63 - 8 * idx -: 8];
      end
   endfunction

endpackage

// File: src/scl_match.sv
// Per-byte command parser with incremental keyword matching.
// Depends on scl_pkg.
module scl_match (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            byte_in,
   output scl_pkg::result_type   result
);

   logic                     in_cmd_ff,  in_cmd_in;
   logic [scl_pkg::LEN_W-1:0] len_ff,    len_in;
   logic [scl_pkg::LEN_W-1:0] eff_ff,    eff_in;
   logic                     zero_ff,    zero_in;
   logic                     pfx_ff,     pfx_in;
   logic [4:0]               act_ff,     act_in;

   localparam logic [scl_pkg::LEN_W-1:0] LAST_LEN = scl_pkg::LEN_W'(scl_pkg::LINE_BYTES - 1);
   localparam logic [scl_pkg::LEN_W-1:0] PLEN     = scl_pkg::LEN_W'(scl_pkg::PREFIX_LEN);

   logic [scl_pkg::LEN_W-1:0] aidx;
   logic [4:0]                act_hit;

   always_comb begin
      aidx = eff_ff - PLEN;
      act_hit[0] = (aidx < scl_pkg::LEN_W'(scl_pkg::TOGGLE_LEN)) &&
                   (byte_in == scl_pkg::word_char(scl_pkg::WORD_TOGGLE, aidx[2:0]));
      act_hit[1] = (aidx < scl_pkg::LEN_W'(scl_pkg::CANCEL_LEN)) &&
                   (byte_in == scl_pkg::word_char(scl_pkg::WORD_CANCEL, aidx[2:0]));
      act_hit[2] = (aidx < scl_pkg::LEN_W'(scl_pkg::RECOVERY_LEN)) &&
                   (byte_in == scl_pkg::word_char(scl_pkg::WORD_RECOVERY, aidx[2:0]));
      act_hit[3] = (aidx < scl_pkg::LEN_W'(scl_pkg::RESET_LEN)) &&
                   (byte_in == scl_pkg::word_char(scl_pkg::WORD_RESET, aidx[2:0]));
      act_hit[4] = (aidx < scl_pkg::LEN_W'(scl_pkg::FORGET_LEN)) &&
                   (byte_in == scl_pkg::word_char(scl_pkg::WORD_FORGET, aidx[2:0]));
   end

   always_comb begin
      in_cmd_in = in_cmd_ff;
      len_in    = len_ff;
      eff_in    = eff_ff;
      zero_in   = zero_ff;
      pfx_in    = pfx_ff;
      act_in    = act_ff;
      result.consumed = 1'b1;
      result.command  = scl_pkg::CMD_NONE;

      if (!in_cmd_ff) begin
         if (byte_in == scl_pkg::CHAR_START) begin
            in_cmd_in = 1'b1;
            len_in    = '0;
            eff_in    = '0;
            zero_in   = 1'b0;
            pfx_in    = 1'b1;
            act_in    = '1;
         end else begin
            result.consumed = 1'b0;
         end
      end else if (byte_in == scl_pkg::CHAR_CR) begin
         in_cmd_in = 1'b1;
      end else if (byte_in == scl_pkg::CHAR_LF) begin
         in_cmd_in = 1'b0;
         if (eff_ff < PLEN || !pfx_ff)
            result.command = scl_pkg::CMD_BAD_PREFIX;
         else if (act_ff[0] && eff_ff == scl_pkg::LEN_W'(scl_pkg::PREFIX_LEN + scl_pkg::TOGGLE_LEN))
            result.command = scl_pkg::CMD_TOGGLE;
         else if (act_ff[1] && eff_ff == scl_pkg::LEN_W'(scl_pkg::PREFIX_LEN + scl_pkg::CANCEL_LEN))
            result.command = scl_pkg::CMD_CANCEL;
         else if ((act_ff[2] &&
                   eff_ff == scl_pkg::LEN_W'(scl_pkg::PREFIX_LEN + scl_pkg::RECOVERY_LEN)) ||
                  (act_ff[3] &&
                   eff_ff == scl_pkg::LEN_W'(scl_pkg::PREFIX_LEN + scl_pkg::RESET_LEN)) ||
                  (act_ff[4] &&
                   eff_ff == scl_pkg::LEN_W'(scl_pkg::PREFIX_LEN + scl_pkg::FORGET_LEN)))
            result.command = scl_pkg::CMD_RECOVERY;
         else
            result.command = scl_pkg::CMD_BAD_ACTION;
      end else if (len_ff == LAST_LEN) begin
         in_cmd_in = 1'b0;
         len_in    = '0;
         result.command = scl_pkg::CMD_TOO_LONG;
      end else begin
         len_in = len_ff + 1'b1;
         if (!zero_ff) begin
            if (byte_in == scl_pkg::CHAR_NUL) begin
               zero_in = 1'b1;
            end else begin
               eff_in = eff_ff + 1'b1;
               if (eff_ff < PLEN)
                  pfx_in = pfx_ff &&
                           (byte_in == scl_pkg::word_char(scl_pkg::WORD_PREFIX, eff_ff[2:0]));
               else
                  act_in = act_ff & act_hit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cmd_ff <= 1'b0;
         len_ff    <= '0;
         eff_ff    <= '0;
         zero_ff   <= 1'b0;
         pfx_ff    <= 1'b1;
         act_ff    <= '1;
      end else if (step) begin
         in_cmd_ff <= in_cmd_in;
         len_ff    <= len_in;
         eff_ff    <= eff_in;
         zero_ff   <= zero_in;
         pfx_ff    <= pfx_in;
         act_ff    <= act_in;
      end
   end

endmodule

// File: src/serial_command_line_matcher.sv
// Top level of the serial command line matcher: input register, parser, result register.
// Depends on scl_pkg and scl_match.
//
// One byte per transaction, one result per byte. An accepted byte sits in the
// input register; its result is then registered in the result register and
// presented from there. A new byte is accepted every cycle while results are
// taken. A stalled result holds the byte behind it, and the input stalls once
// both registers are full. Keyword matching is updated per byte, so the close
// on line feed needs only flag and length compares.
module serial_command_line_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_consumed,
   output logic [2:0] rsp_command
);

   logic                 in_vld_ff,  in_vld_in;
   logic [7:0]           in_byte_ff;
   logic                 out_vld_ff, out_vld_in;
   scl_pkg::result_type  out_res_ff;
   scl_pkg::result_type  match_res;
   logic                 out_adv;

   assign out_adv    = !out_vld_ff || rsp_ready;
   assign req_ready  = !in_vld_ff || out_adv;
   assign in_vld_in  = req_ready ? req_valid : in_vld_ff;
   assign out_vld_in = out_adv ? in_vld_ff : out_vld_ff;

   scl_match u_match (
      .clock   (clock),
      .reset   (reset),
      .step    (in_vld_ff && out_adv),
      .byte_in (in_byte_ff),
      .result  (match_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         in_byte_ff <= req_byte_in;
      if (in_vld_ff && out_adv)
         out_res_ff <= match_res;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_consumed = out_res_ff.consumed;
   assign rsp_command  = out_res_ff.command;

endmodule

// File: src/scl_checker.sv
// Port-level checks for serial_command_line_matcher, bound to the top level.
// Depends on scl_pkg.
module scl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_consumed,
   input logic [2:0] rsp_command
);

   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_command <= scl_pkg::CMD_TOO_LONG)
      else $error("command code out of range");

   a_pass_no_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_consumed) |-> rsp_command == scl_pkg::CMD_NONE)
      else $error("passed byte carries a command");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_command) && $stable(rsp_consumed))
      else $error("stalled result changed");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with no waiting result");

endmodule

bind serial_command_line_matcher scl_checker u_scl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_consumed (rsp_consumed),
   .rsp_command  (rsp_command)
);
